// ----- sv/port_name_fifo_cache_defines.svh -----
// Assertion macros for the port name cache checker.
// No dependencies; the including module must provide clk and rst.
`ifndef PORT_NAME_FIFO_CACHE_DEFINES_SVH
`define PORT_NAME_FIFO_CACHE_DEFINES_SVH

// Property checked outside reset
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included
`define PFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pfc_pkg.sv -----
// Shared types and constants for the port name cache.
// No dependencies.
package pfc_pkg;

  localparam int LIMIT     = 15;
  localparam int CAPACITY  = LIMIT + 1;
  localparam int NAME_BITS = 32;
  localparam int PORT_W    = 16;
  localparam int TAG_W     = 32;
  localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  name_tag;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic [TAG_W-1:0] found_tag;
    logic             added;
  } out_t;

  // Access request from the controller to the slot table
  typedef struct packed {
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [PORT_W-1:0]    wr_port;
    logic [NAME_BITS-1:0] wr_tag;
  } tbl_req_t;

endpackage

// ----- sv/pfc_table.sv -----
// Slot table: port and tag memories, one write and one registered read per cycle.
// Depends on pfc_pkg.
module pfc_table (
  input  logic                          clk,
  input  pfc_pkg::tbl_req_t             req,
  output logic [pfc_pkg::PORT_W-1:0]    rd_port,
  output logic [pfc_pkg::NAME_BITS-1:0] rd_tag
);

  logic [pfc_pkg::PORT_W-1:0]    port_mem [pfc_pkg::CAPACITY];
  logic [pfc_pkg::NAME_BITS-1:0] tag_mem  [pfc_pkg::CAPACITY];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      port_mem[req.wr_addr] <= req.wr_port;
      tag_mem[req.wr_addr]  <= req.wr_tag;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_port <= port_mem[req.rd_addr];
      rd_tag  <= tag_mem[req.rd_addr];
    end
  end

endmodule

// ----- sv/port_name_fifo_cache.sv -----
// Top level of the port name cache: scan controller plus slot table.
// Depends on pfc_pkg and pfc_table.
//
// Fully associative cache of up to 16 port/name-tag entries with first-in
// first-out replacement. An item is taken when start is high and busy is low;
// its result appears on result for one cycle with done high, and must be
// captured then since there is no back-pressure. The stored entries are
// compared one per cycle through the single read port of the slot memory;
// a scan ends on a hit or once every valid entry is compared, and the next item
// can be taken in the cycle that done is shown. A new entry is written in the
// same edge that produces the result, before the next item issues its first
// read, so reads and writes never overlap.
module port_name_fifo_cache (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pfc_pkg::in_t  item,
  output logic          busy,
  output logic          done,
  output pfc_pkg::out_t result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                        state, state_next;
  pfc_pkg::in_t                  item_q;
  logic [pfc_pkg::COUNT_W-1:0]   idx;
  logic                          pend;
  logic [pfc_pkg::COUNT_W-1:0]   count;
  logic [pfc_pkg::SLOT_W-1:0]    newest;

  pfc_pkg::tbl_req_t             req;
  logic [pfc_pkg::PORT_W-1:0]    rd_port;
  logic [pfc_pkg::NAME_BITS-1:0] rd_tag;
  logic                          accept;
  logic                          match;
  logic                          decide;
  logic                          is_insert;
  logic [pfc_pkg::SLOT_W-1:0]    next_slot;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign is_insert = (item_q.kind == pfc_pkg::KIND_INSERT);

  // Compare the entry read last cycle; stop on a hit or when reads run out
  assign match  = pend && (rd_port == item_q.port);
  assign decide = (state == ST_SCAN) && (match || !req.rd_en);

  // Slot that takes a new entry
  always_comb begin
    if (count == '0) begin
      next_slot = '0;
    end else if (newest == pfc_pkg::SLOT_W'(pfc_pkg::LIMIT)) begin
      next_slot = '0;
    end else begin
      next_slot = newest + 1'b1;
    end
  end

  // Table requests
  always_comb begin
    req.rd_en   = (state == ST_SCAN) && (idx < count);
    req.rd_addr = idx[pfc_pkg::SLOT_W-1:0];
    req.wr_en   = decide && is_insert && !match;
    req.wr_addr = next_slot;
    req.wr_port = item_q.port;
    req.wr_tag  = item_q.name_tag[pfc_pkg::NAME_BITS-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (decide) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  pfc_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_port (rd_port),
    .rd_tag  (rd_tag)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      pend   <= 1'b0;
      count  <= '0;
      newest <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= decide;
      pend  <= req.rd_en;
      if (accept) begin
        idx <= '0;
      end else if (req.rd_en) begin
        idx <= idx + 1'b1;
      end
      if (req.wr_en) begin
        newest <= next_slot;
        if (count < pfc_pkg::COUNT_W'(pfc_pkg::CAPACITY)) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (decide) begin
      result.hit       <= match;
      result.added     <= is_insert && !match;
      result.found_tag <= (match && !is_insert) ? pfc_pkg::TAG_W'(rd_tag) : '0;
    end
  end

endmodule

// ----- sv/pfc_checker.sv -----
// Port-level checker for the port name cache, bound to the top level.
// Depends on pfc_pkg and port_name_fifo_cache_defines.svh.
`include "port_name_fifo_cache_defines.svh"

module pfc_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input pfc_pkg::in_t  item,
  input logic          busy,
  input logic          done,
  input pfc_pkg::out_t result
);

  // An accepted beat keeps the block busy until its result
  `PFC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  // A result is shown only once the block is free again
  `PFC_ASSERT(a_done_idle, done |-> !busy, "result shown while busy")
  // One result per beat: strobes never come back to back
  `PFC_ASSERT(a_done_single, done |=> !done, "result strobe held two cycles")
  // A new entry is never a hit and carries no tag
  `PFC_ASSERT(a_added_clean, (done && result.added) |-> (!result.hit && result.found_tag == '0),
              "added entry reported as hit or with tag")
  // Out of reset the block is idle with no result
  `PFC_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind port_name_fifo_cache pfc_checker u_pfc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- tb/port_name_fifo_cache_test.sv -----
// Self-checking testbench for the port name cache (FIFO replacement).
// Depends on pfc_pkg and port_name_fifo_cache; predicts every reply in-line.
module port_name_fifo_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1200;
  localparam int POOL_SIZE    = 24;
  localparam logic [pfc_pkg::TAG_W-1:0] TAG_KEEP =
    {pfc_pkg::TAG_W{1'b1}} >> (pfc_pkg::TAG_W - pfc_pkg::NAME_BITS);

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  pfc_pkg::in_t  item  = '0;
  logic          busy;
  logic          done;
  pfc_pkg::out_t result;

  port_name_fifo_cache dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #10 clk = ~clk;

  // Shadow copy of the cache contents
  logic [pfc_pkg::PORT_W-1:0] held_port [pfc_pkg::CAPACITY];
  logic [pfc_pkg::TAG_W-1:0]  held_tag  [pfc_pkg::CAPACITY];
  int                         held_count = 0;
  int                         newest     = 0;

  pfc_pkg::in_t  pending_requests [$];
  pfc_pkg::out_t predicted_replies [$];
  pfc_pkg::out_t want;
  int   issued   = 0;
  int   accepted = 0;
  int   errors   = 0;
  int   stall    = 0;
  int   hold_off = 0;
  bit   fast_phase = 1'b0;

  // Search; an insert that misses becomes the newest entry (overwrites oldest when full)
  function automatic pfc_pkg::out_t cache_access(pfc_pkg::in_t beat);
    pfc_pkg::out_t reply;
    int            where;
    int            next;
    reply = '0;
    where = -1;
    for (int i = 0; i < held_count; i++) begin
      if (where < 0 && held_port[i] == beat.port) where = i;
    end
    reply.hit = (where >= 0);
    if (beat.kind == pfc_pkg::KIND_LOOKUP) begin
      if (where >= 0) reply.found_tag = held_tag[where];
    end else if (where < 0) begin
      next = (held_count == 0) ? 0 : (newest + 1) % pfc_pkg::CAPACITY;
      held_port[next] = beat.port;
      held_tag[next]  = beat.name_tag & TAG_KEEP;
      newest = next;
      if (held_count < pfc_pkg::CAPACITY) held_count++;
      reply.added = 1'b1;
    end
    return reply;
  endfunction

  function automatic pfc_pkg::in_t make_beat(logic k, logic [pfc_pkg::PORT_W-1:0] p,
                                             logic [pfc_pkg::TAG_W-1:0] t);
    pfc_pkg::in_t beat;
    beat.kind     = k;
    beat.port     = p;
    beat.name_tag = t;
    return beat;
  endfunction

  // Driver: present a beat at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
    end else if (start && issued != accepted) begin
      // beat still waiting for busy to drop
    end else if (hold_off > 0) begin
      start <= 1'b0;
      hold_off = hold_off - 1;
    end else if (pending_requests.size() > 0) begin
      item  <= pending_requests.pop_front();
      start <= 1'b1;
      issued = issued + 1;
      if ($urandom_range(0, 39) == 0) fast_phase = !fast_phase;
      hold_off = fast_phase ? 0 : $urandom_range(0, 18);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check replies first, then predict the beat taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected reply hit=%0d tag=%h added=%0d", $time,
                   result.hit, result.found_tag, result.added);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (result.hit !== want.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want.hit, result.hit);
            errors++;
          end
          if (result.found_tag !== want.found_tag) begin
            $display("%0t: found_tag expected %h got %h", $time,
                     want.found_tag, result.found_tag);
            errors++;
          end
          if (result.added !== want.added) begin
            $display("%0t: added expected %0d got %0d", $time, want.added, result.added);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predicted_replies.push_back(cache_access(item));
        accepted = accepted + 1;
      end
      stall <= (done || (start && !busy)) ? 0 : stall + 1;
    end
  end

  // Watchdog on cycles with no traffic at all
  initial begin
    while (stall < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus, reset and end of run
  logic [pfc_pkg::PORT_W-1:0] pool [POOL_SIZE];
  logic [pfc_pkg::PORT_W-1:0] pick;
  logic                       op;
  int                         roll;

  initial begin
    // Empty table, extremes, duplicate insert
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'h0000, 32'hFFFF_FFFF));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_INSERT, 16'h0000, 32'h0000_0000));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'h0000, 32'h0000_0000));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'hFFFF, 32'h0000_0000));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_INSERT, 16'h0000, 32'h1234_5678));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'h0000, 32'hA5A5_A5A5));
    // Fill the table, then overflow to drop the oldest entry
    for (int i = 1; i <= pfc_pkg::CAPACITY - 2; i++)
      pending_requests.push_back(make_beat(pfc_pkg::KIND_INSERT, 16'(i), $urandom));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_INSERT, 16'h8000, 32'h8000_0001));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'h0000, 32'h0000_0000));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'h0001, 32'h0000_0000));
    pending_requests.push_back(make_beat(pfc_pkg::KIND_LOOKUP, 16'h8000, 32'h0000_0000));

    // Random traffic over a port pool a bit larger than the table
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = pfc_pkg::PORT_W'($urandom);
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      pick = (roll < 10) ? pfc_pkg::PORT_W'($urandom) : pool[$urandom_range(0, POOL_SIZE - 1)];
      op   = ($urandom_range(0, 1) == 0) ? pfc_pkg::KIND_INSERT : pfc_pkg::KIND_LOOKUP;
      pending_requests.push_back(make_beat(op, pick, $urandom));
      if ($urandom_range(0, 19) == 0)
        pool[$urandom_range(2, POOL_SIZE - 1)] = pfc_pkg::PORT_W'($urandom);
    end

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || issued != accepted) @(negedge clk);
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && predicted_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
